// ===== rtl/dbrr_pkg.sv =====
// Shared types and constants of the definite-length block response reframer.
`default_nettype none

package dbrr_pkg;

  // Characters and limits of the block format
  localparam logic [7:0] CharHash = 8'h23;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharOne  = 8'h31;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharNl   = 8'h0A;
  localparam int unsigned MinBlockLen   = 10;
  localparam int unsigned MaxRespBytes  = 4096;
  localparam int unsigned PosMax        = 13'h1FFF;

  // Output bytes per queue entry and queue depth
  localparam int unsigned EntryBytes = 5;
  localparam int unsigned CntW       = $clog2(EntryBytes + 1);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_HASH,
    MODE_DIGITS,
    MODE_PAYLOAD,
    MODE_DROP,
    MODE_TEXT
  } dbrr_mode_e;

  typedef struct packed {
    logic [7:0]  resp_byte;
    logic [12:0] resp_length;
    logic        resp_end;
  } dbrr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } dbrr_out_t;

  // One classified input item: up to five bytes, last mark on the final one
  typedef struct packed {
    logic [EntryBytes-1:0][7:0] bytes;
    logic [CntW-1:0]            cnt;
    logic                       last;
  } dbrr_entry_t;

endpackage

`default_nettype wire

// ===== rtl/dbrr_front.sv =====
// Front part: accepts response bytes, tracks the header parse and classifies each item.
`default_nettype none

module dbrr_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire dbrr_pkg::dbrr_in_t in_data_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output dbrr_pkg::dbrr_entry_t   entry_o
);
  import dbrr_pkg::*;

  dbrr_mode_e  mode_q, mode_d;
  logic [12:0] pos_q, pos_d;
  logic [3:0]  dt_q, dt_d;
  logic [31:0] pc_q, pc_d;
  logic [12:0] pl_q, pl_d;

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic [12:0] len;
  logic [7:0]  b_digit;
  logic        is_digit19;
  logic [31:0] pc_new;
  logic [12:0] need;
  logic [12:0] avail;
  logic [12:0] pay;
  logic [12:0] pl_new;
  dbrr_entry_t entry;

  // Build the entry of a text byte, optionally after a held-back '#'
  function automatic dbrr_entry_t text_entry(logic pre, logic [7:0] tb, logic tfin);
    dbrr_entry_t e;
    logic        nl;
    e  = '0;
    nl = tfin && (tb != CharNl);
    if (pre) begin
      e.bytes[0] = CharHash;
      e.bytes[1] = tb;
      e.bytes[2] = CharNl;
      e.cnt      = nl ? CntW'(3) : CntW'(2);
    end else begin
      e.bytes[0] = tb;
      e.bytes[1] = CharNl;
      e.cnt      = nl ? CntW'(2) : CntW'(1);
    end
    e.last = tfin;
    return e;
  endfunction

  // Build a block header entry
  function automatic dbrr_entry_t header_entry(logic [12:0] hp, logic hlast);
    dbrr_entry_t e;
    e          = '0;
    e.bytes[0] = CharHash;
    e.bytes[1] = hp[7:0];
    e.bytes[2] = {3'b000, hp[12:8]};
    e.cnt      = CntW'(EntryBytes);
    e.last     = hlast;
    return e;
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign b          = in_data_i.resp_byte;
  assign fin        = in_data_i.resp_end;

  // Clamp the length and prepare the digit arithmetic
  always_comb begin
    len = (32'(in_data_i.resp_length) > MaxRespBytes) ? 13'(MaxRespBytes)
                                                      : in_data_i.resp_length;
    b_digit    = b - CharZero;
    is_digit19 = (b >= CharOne) && (b <= CharNine);
    pc_new     = (pc_q << 3) + (pc_q << 1) + 32'(b) - 32'(CharZero);
    need       = 13'd2 + 13'(dt_q);
    avail      = (len >= need) ? (len - need) : 13'd0;
    pay        = (32'(avail) < pc_new) ? avail : pc_new[12:0];
    if (fin) begin
      pay = 13'd0;
    end
    pl_new = (pl_q != 13'd0) ? (pl_q - 13'd1) : pl_q;
  end

  // Next state and classification of the accepted item
  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    dt_d   = dt_q;
    pc_d   = pc_q;
    pl_d   = pl_q;
    entry  = '0;
    unique case (mode_q)
      MODE_HASH: begin
        if (is_digit19 && (len >= 13'd2 + 13'(b_digit[3:0]))) begin
          dt_d   = b_digit[3:0];
          pc_d   = 32'd0;
          mode_d = MODE_DIGITS;
          if (fin) begin
            entry = header_entry(13'd0, 1'b1);
          end
        end else begin
          entry  = text_entry(1'b1, b, fin);
          mode_d = MODE_TEXT;
        end
      end
      MODE_DIGITS: begin
        pc_d = pc_new;
        if ((pos_q >= 13'd1 + 13'(dt_q)) || fin) begin
          entry  = header_entry(pay, (pay == 13'd0) || fin);
          pl_d   = pay;
          mode_d = (pay == 13'd0) ? MODE_DROP : MODE_PAYLOAD;
        end
      end
      MODE_PAYLOAD: begin
        pl_d           = pl_new;
        entry.bytes[0] = b;
        entry.cnt      = CntW'(1);
        entry.last     = (pl_new == 13'd0) || fin;
        if (pl_new == 13'd0) begin
          mode_d = MODE_DROP;
        end
      end
      MODE_DROP: begin
        entry = '0;
      end
      MODE_TEXT: begin
        entry = text_entry(1'b0, b, fin);
      end
      default: begin
        pos_d = 13'd0;
        if (!fin && (b == CharHash) && (32'(len) >= MinBlockLen)) begin
          mode_d = MODE_HASH;
        end else begin
          entry  = text_entry(1'b0, b, fin);
          mode_d = MODE_TEXT;
        end
      end
    endcase
    // Return to idle at the end of a response, else advance the position
    if (fin) begin
      mode_d = MODE_IDLE;
      pos_d  = 13'd0;
      dt_d   = 4'd0;
      pc_d   = 32'd0;
      pl_d   = 13'd0;
    end else if (32'(pos_d) < PosMax) begin
      pos_d = pos_d + 13'd1;
    end
  end

  assign push_o  = accept && (entry.cnt != '0);
  assign entry_o = entry;

  // Hold the parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= 13'd0;
      dt_q   <= 4'd0;
      pc_q   <= 32'd0;
      pl_q   <= 13'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      dt_q   <= dt_d;
      pc_q   <= pc_d;
      pl_q   <= pl_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dbrr_queue.sv =====
// Short queue of classified entries between the front and back parts.
`default_nettype none

module dbrr_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire dbrr_pkg::dbrr_entry_t entry_i,
  output logic                       full_o,
  output logic                       head_valid_o,
  output dbrr_pkg::dbrr_entry_t      head_o,
  input  wire logic                  pop_i
);
  import dbrr_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntQW = $clog2(QueueDepth + 1);

  dbrr_entry_t      mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [CntQW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntQW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  // Advance the pointers and the fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntQW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dbrr_back.sv =====
// Back part: sends the bytes of each queued entry, one per cycle while out_ready_i holds, through an output register.
`default_nettype none

module dbrr_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  head_valid_i,
  input  wire dbrr_pkg::dbrr_entry_t head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output dbrr_pkg::dbrr_out_t        out_data_o
);
  import dbrr_pkg::*;

  localparam int unsigned IdxW = $clog2(EntryBytes);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  dbrr_out_t       out_data_q, out_data_d;
  logic            load;
  logic            at_final;

  assign load     = head_valid_i && (!out_valid_q || out_ready_i);
  assign at_final = (CntW'(idx_q) == head_i.cnt - CntW'(1));
  assign pop_o    = load && at_final;

  // Load the next byte of the head entry and step through it
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d         = 1'b1;
      out_data_d.out_byte = head_i.bytes[idx_q];
      out_data_d.out_last = head_i.last && at_final;
      idx_d               = at_final ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/definite_block_response_reframer_unit.sv =====
// Top level of the definite-length block response reframer.
`default_nettype none

// Takes the bytes of an instrument response and reframes a definite-length
// block ('#', digit count, length digits, payload) as '#' plus a 4-byte
// little-endian payload length and the payload; any other response passes
// through as text, closed by a newline when it lacks one. Text and payload
// bytes run at one item per cycle when nothing stalls; an item passes
// through the queue and the output register. The back part sends one
// output byte per cycle unless stalled, from a two-entry queue, so a block
// header (five bytes) or a '#' held back before text (up to three bytes)
// holds it until sent; input stalls once the queue fills. Header bytes are
// taken at one per cycle while the queue has room; only the last outputs.
module definite_block_response_reframer_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dbrr_pkg::dbrr_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dbrr_pkg::dbrr_out_t      out_data_o
);
  import dbrr_pkg::*;

  logic        push;
  logic        full;
  logic        head_valid;
  logic        pop;
  dbrr_entry_t entry;
  dbrr_entry_t head;

  dbrr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry)
  );

  dbrr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  dbrr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
